>>> sv/ftmr_pkg.sv
// ---------------------------------------------------------------------------
// ftmr_pkg
// Shared types, register codes and helpers for the fat tree minimal route
// candidate generator.
// ---------------------------------------------------------------------------
package ftmr_pkg;

  localparam int MAX_PORTS   = 64;
  localparam int MAX_RAILS   = 16;
  localparam int MAX_VCS     = 4;
  localparam int SPINE_LIMIT = 16;

  localparam int RV_W      = 16;
  localparam int MOD_BITS  = 4;                 // random bits reduced per stage
  localparam int MOD_STAGES = RV_W / MOD_BITS;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RAIL_COUNT      = 3'd0,
    CFG_LEAF_PORTS      = 3'd1,
    CFG_SPINES_PER_RAIL = 3'd2,
    CFG_LEAVES_PER_RAIL = 3'd3,
    CFG_VC_COUNT        = 3'd4
  } cfg_idx_t;

  localparam logic [4:0] RAIL_COUNT_RST      = 5'd1;
  localparam logic [5:0] LEAF_PORTS_RST      = 6'd32;
  localparam logic [4:0] SPINES_PER_RAIL_RST = 5'd16;
  localparam logic [6:0] LEAVES_PER_RAIL_RST = 7'd64;
  localparam logic [2:0] VC_COUNT_RST        = 3'd2;

  typedef struct packed {
    logic [6:0]  here_group;
    logic [7:0]  here_index;
    logic [5:0]  target_group;
    logic [5:0]  target_index;
    logic [15:0] random_value;
  } req_t;

  typedef struct packed {
    logic [5:0] out_port;
    logic [1:0] out_vc;
    logic       last;
  } rsp_t;

  // one request on its way through the modulo stages
  typedef struct packed {
    logic [4:0]  n;      // rotation modulus, 1..16
    logic [6:0]  base;   // port of rotation slot zero
    logic [4:0]  lim;    // slots below lim give ports inside the switch
    logic [1:0]  vmax;   // highest virtual channel
    logic [15:0] rv;
    logic [4:0]  rem;    // partial remainder of rv mod n
  } stage_t;

  // four restoring steps of rv mod n, msb first
  function automatic logic [4:0] mod_step(logic [4:0] rem, logic [MOD_BITS-1:0] bits,
                                          logic [4:0] n);
    logic [5:0] r;
    r = {1'b0, rem};
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      r = {r[4:0], bits[i]};
      if (r >= {1'b0, n}) begin
        r = r - {1'b0, n};
      end
    end
    return r[4:0];
  endfunction

endpackage

>>> sv/fat_tree_min_route_candidates_top.sv
// ---------------------------------------------------------------------------
// fat_tree_min_route_candidates_top
// Minimal route candidates for a two-level multi-rail fat tree: decode stage,
// four modulo stages for the rotation start, then a candidate enumerator.
// ---------------------------------------------------------------------------
// a request passes the decode stage, the modulo stages and the enumerator registers
// throughput: one candidate per cycle except on skipped ports; a request holds the
//   enumerator for each virtual channel of each inside port and each skipped port
// requests queue in the five pipeline stages; busy rises only when all are full
// results cannot be held off by the receiver
// synchronous reset empties the pipeline and loads the register defaults
module fat_tree_min_route_candidates_top
  import ftmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       result_valid,
  output rsp_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data
);

  // configuration registers
  logic [4:0] rail_count;
  logic [5:0] leaf_ports;
  logic [4:0] spines_per_rail;
  logic [6:0] leaves_per_rail;
  logic [2:0] vc_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rail_count      <= RAIL_COUNT_RST;
      leaf_ports      <= LEAF_PORTS_RST;
      spines_per_rail <= SPINES_PER_RAIL_RST;
      leaves_per_rail <= LEAVES_PER_RAIL_RST;
      vc_count        <= VC_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RAIL_COUNT:      rail_count      <= cfg_data[4:0];
        CFG_LEAF_PORTS:      leaf_ports      <= cfg_data[5:0];
        CFG_SPINES_PER_RAIL: spines_per_rail <= cfg_data[4:0];
        CFG_LEAVES_PER_RAIL: leaves_per_rail <= cfg_data;
        CFG_VC_COUNT:        vc_count        <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // request decode
  logic [4:0] rails_c;
  logic [4:0] spines_c;
  logic [2:0] vcs_c;
  logic [6:0] up_room;
  stage_t     decoded;

  always_comb begin
    rails_c  = (rail_count == 5'd0) ? 5'd1 :
               (rail_count > 5'(MAX_RAILS)) ? 5'(MAX_RAILS) : rail_count;
    spines_c = (spines_per_rail == 5'd0) ? 5'd1 :
               (spines_per_rail > 5'(SPINE_LIMIT)) ? 5'(SPINE_LIMIT) : spines_per_rail;
    vcs_c    = (vc_count == 3'd0) ? 3'd1 :
               (vc_count > 3'(MAX_VCS)) ? 3'(MAX_VCS) : vc_count;
    up_room  = 7'(MAX_PORTS) - {1'b0, leaf_ports};

    decoded.vmax = 2'(vcs_c - 3'd1);
    decoded.rv   = req.random_value;
    decoded.rem  = 5'd0;
    if (req.here_group < leaves_per_rail &&
        req.here_index < {2'b00, leaf_ports}) begin
      // endpoint: all rails
      decoded.n    = rails_c;
      decoded.base = 7'd0;
      decoded.lim  = rails_c;
    end else if (req.here_group == {1'b0, req.target_group}) begin
      decoded.n    = 5'd1;
      decoded.base = {1'b0, req.target_index};
      decoded.lim  = 5'd1;
    end else if (req.here_group == leaves_per_rail) begin
      decoded.n    = 5'd1;
      decoded.base = {1'b0, req.target_group};
      decoded.lim  = 5'd1;
    end else begin
      // leaf going up: spine ports that fit in the switch
      decoded.n    = spines_c;
      decoded.base = {1'b0, leaf_ports};
      decoded.lim  = (up_room < {2'b00, spines_c}) ? up_room[4:0] : spines_c;
    end
  end

  // pipeline: stage 0 holds the decoded request, stages 1..4 reduce rv
  stage_t pipe [0:MOD_STAGES];
  logic   valid [0:MOD_STAGES];
  logic   rdy [0:MOD_STAGES];
  logic   take;

  assign rdy[MOD_STAGES] = !valid[MOD_STAGES] || take;
  assign busy            = !rdy[0];

  genvar g;
  generate
    for (g = 0; g < MOD_STAGES; g++) begin : g_rdy
      assign rdy[g] = !valid[g] || rdy[g + 1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (rdy[0]) begin
      valid[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && start) begin
      pipe[0] <= decoded;
    end
  end

  generate
    for (g = 1; g <= MOD_STAGES; g++) begin : g_mod
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[g] <= 1'b0;
        end else if (rdy[g]) begin
          valid[g] <= valid[g - 1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[g] && valid[g - 1]) begin
          pipe[g].n    <= pipe[g - 1].n;
          pipe[g].base <= pipe[g - 1].base;
          pipe[g].lim  <= pipe[g - 1].lim;
          pipe[g].vmax <= pipe[g - 1].vmax;
          pipe[g].rv   <= pipe[g - 1].rv;
          pipe[g].rem  <= mod_step(pipe[g - 1].rem,
                                   pipe[g - 1].rv[RV_W - 1 - MOD_BITS * (g - 1) -: MOD_BITS],
                                   pipe[g - 1].n);
        end
      end
    end
  endgenerate

  // candidate enumerator
  logic       active;
  logic [3:0] slot;
  logic [1:0] vc;
  logic [6:0] base;
  logic [3:0] n_m1;
  logic [4:0] lim;
  logic [1:0] vmax;
  logic [3:0] last_slot;

  logic       slot_ok;
  logic       done_now;
  logic [3:0] slot_wrap;
  logic [3:0] ld_start;
  logic [4:0] ld_lim;
  logic [3:0] ld_last;
  logic [6:0] port_sum;

  assign slot_ok   = ({1'b0, slot} < lim);
  assign done_now  = active && slot_ok && (slot == last_slot) && (vc == vmax);
  assign take      = !active || done_now;
  assign slot_wrap = (slot == n_m1) ? 4'd0 : slot + 4'd1;

  // final emitted slot: the last inside-switch slot in rotation order
  assign ld_start = pipe[MOD_STAGES].rem[3:0];
  assign ld_lim   = pipe[MOD_STAGES].lim;
  assign ld_last  = (ld_start == 4'd0 || {1'b0, ld_start} > ld_lim) ?
                    4'(ld_lim - 5'd1) : ld_start - 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (take) begin
      active <= valid[MOD_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (valid[MOD_STAGES]) begin
        slot      <= ld_start;
        vc        <= 2'd0;
        base      <= pipe[MOD_STAGES].base;
        n_m1      <= 4'(pipe[MOD_STAGES].n - 5'd1);
        lim       <= ld_lim;
        vmax      <= pipe[MOD_STAGES].vmax;
        last_slot <= ld_last;
      end
    end else if (!slot_ok || vc == vmax) begin
      slot <= slot_wrap;
      vc   <= 2'd0;
    end else begin
      vc <= vc + 2'd1;
    end
  end

  assign port_sum        = base + {3'b000, slot};
  assign result_valid    = active && slot_ok;
  assign result.out_port = port_sum[5:0];
  assign result.out_vc   = vc;
  assign result.last     = done_now;

  // checks
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> (valid[0] && valid[1] && valid[2] && valid[3] && valid[4] && active))
    else $error("busy with an empty pipeline stage");

  a_vc_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.out_vc <= vmax))
    else $error("virtual channel above configured count");

  a_fresh_vc: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> (!result_valid || result.out_vc == 2'd0))
    else $error("next request did not start at virtual channel zero");

  a_port_inside: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (port_sum < 7'(MAX_PORTS)))
    else $error("candidate port outside the switch");

endmodule
